// ===== hw/rtl/ttdc_pkg.sv =====
package ttdc_pkg;

  localparam int COLUMNS_DEF     = 64;
  localparam int ROWS_DEF        = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int DATA_W   = 8;
  localparam int CODE_W   = 7;
  localparam int ADDR_W   = 10;
  localparam int CURSOR_W = 10;
  localparam int TOP_W    = 4;
  localparam int STROBE_BIT = 7;

  localparam logic [CODE_W-1:0] SPACE_CHAR = 7'h20;

  localparam logic [CODE_W-1:0] CODE_NUL        = 7'h00;
  localparam logic [CODE_W-1:0] CODE_IGNORE_A   = 7'h04;
  localparam logic [CODE_W-1:0] CODE_LEFT       = 7'h08;
  localparam logic [CODE_W-1:0] CODE_RIGHT      = 7'h09;
  localparam logic [CODE_W-1:0] CODE_DOWN       = 7'h0a;
  localparam logic [CODE_W-1:0] CODE_UP         = 7'h0b;
  localparam logic [CODE_W-1:0] CODE_PAGE_CLEAR = 7'h0c;
  localparam logic [CODE_W-1:0] CODE_CR         = 7'h0d;
  localparam logic [CODE_W-1:0] CODE_IGNORE_B   = 7'h18;
  localparam logic [CODE_W-1:0] CODE_IGNORE_C   = 7'h19;
  localparam logic [CODE_W-1:0] CODE_ERASE_LINE = 7'h1a;
  localparam logic [CODE_W-1:0] CODE_SCROLL     = 7'h1b;
  localparam logic [CODE_W-1:0] CODE_HOME       = 7'h1c;
  localparam logic [CODE_W-1:0] CODE_COL0       = 7'h1d;

  typedef enum logic [3:0] {
    OP_READ,
    OP_REPORT,
    OP_LEFT,
    OP_RIGHT,
    OP_DOWN,
    OP_UP,
    OP_CLEAR,
    OP_CR,
    OP_ERASE_LINE,
    OP_SCROLL,
    OP_HOME,
    OP_COL0,
    OP_CHAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

// ===== hw/rtl/ttdc_front.sv =====
module ttdc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [ttdc_pkg::DATA_W-1:0] in_data_byte,
  input  logic [ttdc_pkg::ADDR_W-1:0] in_cell_address,
  input  logic                        q_full,
  input  logic                        back_busy,
  output logic                        q_push,
  output ttdc_pkg::cmd_t              q_entry
);

  logic [ttdc_pkg::DATA_W-1:0] latch_r;
  logic [ttdc_pkg::DATA_W-1:0] latch_nxt;
  logic [ttdc_pkg::CODE_W-1:0] code;
  ttdc_pkg::op_t               op;

  assign in_stall = q_full | back_busy;
  assign q_push   = in_valid & ~in_stall;
  assign code     = in_data_byte[ttdc_pkg::CODE_W-1:0];

  always_comb begin
    if (in_action) begin
      op = ttdc_pkg::OP_READ;
    end else if ((in_data_byte == latch_r) || !in_data_byte[ttdc_pkg::STROBE_BIT]) begin
      op = ttdc_pkg::OP_REPORT;
    end else begin
      case (code)
        ttdc_pkg::CODE_NUL,
        ttdc_pkg::CODE_IGNORE_A,
        ttdc_pkg::CODE_IGNORE_B,
        ttdc_pkg::CODE_IGNORE_C:   op = ttdc_pkg::OP_REPORT;
        ttdc_pkg::CODE_LEFT:       op = ttdc_pkg::OP_LEFT;
        ttdc_pkg::CODE_RIGHT:      op = ttdc_pkg::OP_RIGHT;
        ttdc_pkg::CODE_DOWN:       op = ttdc_pkg::OP_DOWN;
        ttdc_pkg::CODE_UP:         op = ttdc_pkg::OP_UP;
        ttdc_pkg::CODE_PAGE_CLEAR: op = ttdc_pkg::OP_CLEAR;
        ttdc_pkg::CODE_CR:         op = ttdc_pkg::OP_CR;
        ttdc_pkg::CODE_ERASE_LINE: op = ttdc_pkg::OP_ERASE_LINE;
        ttdc_pkg::CODE_SCROLL:     op = ttdc_pkg::OP_SCROLL;
        ttdc_pkg::CODE_HOME:       op = ttdc_pkg::OP_HOME;
        ttdc_pkg::CODE_COL0:       op = ttdc_pkg::OP_COL0;
        default:                   op = ttdc_pkg::OP_CHAR;
      endcase
    end
  end

  always_comb begin
    q_entry.op   = op;
    q_entry.code = code;
    q_entry.addr = in_cell_address;
  end

  always_comb begin
    latch_nxt = latch_r;
    if (q_push && !in_action) begin
      latch_nxt = in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
    end else begin
      latch_r <= latch_nxt;
    end
  end

endmodule

// ===== hw/rtl/ttdc_queue.sv =====
module ttdc_queue #(
  parameter int DEPTH = ttdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttdc_pkg::cmd_t push_entry,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ttdc_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ttdc_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slots[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/ttdc_back.sv =====
module ttdc_back #(
  parameter int COLUMNS = ttdc_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttdc_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  ttdc_pkg::cmd_t                q_head,
  output logic                          q_pop,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ttdc_pkg::CODE_W-1:0]   out_read_data,
  output logic [ttdc_pkg::CURSOR_W-1:0] out_cursor_index,
  output logic [ttdc_pkg::TOP_W-1:0]    out_top_row
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int RW     = $clog2(ROWS);
  localparam int CLW    = $clog2(COLUMNS);
  localparam int CELL_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int AW     = ((CELL_W > ttdc_pkg::ADDR_W) ? CELL_W : ttdc_pkg::ADDR_W) + 1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_RDMOD,
    ST_RDWAIT,
    ST_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [RW-1:0]                 row_r, row_nxt;
  logic [CLW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                 start_r, start_nxt;
  logic [RW-1:0]                 prow_r, prow_nxt;
  logic [CLW-1:0]                pcol_r, pcol_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [AW-1:0]                 rd_addr_r, rd_addr_nxt;
  logic [ttdc_pkg::CODE_W-1:0]   res_read_r, res_read_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ttdc_pkg::CODE_W-1:0]   out_read_r, out_read_nxt;
  logic [ttdc_pkg::CURSOR_W-1:0] out_cursor_r, out_cursor_nxt;
  logic [ttdc_pkg::TOP_W-1:0]    out_top_r, out_top_nxt;

  logic [ttdc_pkg::CODE_W-1:0]   mem [CELLS];
  logic [ttdc_pkg::CODE_W-1:0]   mem_rdata_r;
  logic                          mem_we;
  logic [CELL_W-1:0]             mem_waddr;
  logic [ttdc_pkg::CODE_W-1:0]   mem_wdata;
  logic                          mem_re;
  logic [CELL_W-1:0]             mem_raddr;

  logic [RW-1:0]                 row_inc, row_dec, start_inc, cur_prow;
  logic                          last_row, last_col;
  logic [CELL_W-1:0]             cursor_full;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row);
    logic [RW:0] s;
    s = {1'b0, top} + {1'b0, row};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [RW-1:0] prow,
                                                input logic [CLW-1:0] pcol);
    return CELL_W'(prow) * CELL_W'(COLUMNS) + CELL_W'(pcol);
  endfunction

  assign row_inc     = (row_r == RW'(ROWS - 1)) ? '0 : row_r + 1'b1;
  assign row_dec     = (row_r == '0) ? RW'(ROWS - 1) : row_r - 1'b1;
  assign start_inc   = (start_r == RW'(ROWS - 1)) ? '0 : start_r + 1'b1;
  assign cur_prow    = phys_row(start_r, row_r);
  assign last_row    = (row_r == RW'(ROWS - 1));
  assign last_col    = (col_r == CLW'(COLUMNS - 1));
  assign cursor_full = cell_of(row_r, col_r);

  assign busy             = (state_r == ST_INIT);
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_r;
  assign out_cursor_index = out_cursor_r;
  assign out_top_row      = out_top_r;
  assign mem_raddr        = CELL_W'(rd_addr_r);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    start_nxt      = start_r;
    prow_nxt       = prow_r;
    pcol_nxt       = pcol_r;
    cnt_nxt        = cnt_r;
    rd_addr_nxt    = rd_addr_r;
    res_read_nxt   = res_read_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_read_nxt   = out_read_r;
    out_cursor_nxt = out_cursor_r;
    out_top_nxt    = out_top_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cell_of(prow_r, pcol_r);
    mem_wdata      = ttdc_pkg::SPACE_CHAR;
    mem_re         = 1'b0;

    case (state_r)
      ST_INIT, ST_SWEEP: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (pcol_r == CLW'(COLUMNS - 1)) begin
          pcol_nxt = '0;
          prow_nxt = (prow_r == RW'(ROWS - 1)) ? '0 : prow_r + 1'b1;
        end else begin
          pcol_nxt = pcol_r + 1'b1;
        end
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_EMIT;
        end
      end

      ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          res_read_nxt = '0;
          state_nxt    = ST_EMIT;
          case (q_head.op)
            ttdc_pkg::OP_READ: begin
              rd_addr_nxt = AW'(q_head.addr);
              state_nxt   = ST_RDMOD;
            end
            ttdc_pkg::OP_LEFT: begin
              if (col_r == '0) begin
                col_nxt = CLW'(COLUMNS - 1);
                row_nxt = row_dec;
              end else begin
                col_nxt = col_r - 1'b1;
              end
            end
            ttdc_pkg::OP_RIGHT: begin
              if (last_col) begin
                col_nxt = '0;
                row_nxt = row_inc;
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            ttdc_pkg::OP_DOWN: begin
              if (last_row) begin
                start_nxt = start_inc;
                prow_nxt  = phys_row(start_inc, row_r);
                pcol_nxt  = col_r;
                cnt_nxt   = CNT_W'(COLUMNS);
                state_nxt = ST_SWEEP;
              end else begin
                row_nxt = row_inc;
              end
            end
            ttdc_pkg::OP_UP: begin
              row_nxt = row_dec;
            end
            ttdc_pkg::OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              start_nxt = '0;
              prow_nxt  = '0;
              pcol_nxt  = '0;
              cnt_nxt   = CNT_W'(CELLS);
              state_nxt = ST_SWEEP;
            end
            ttdc_pkg::OP_CR: begin
              if (col_r != '0) begin
                prow_nxt  = cur_prow;
                pcol_nxt  = col_r;
                cnt_nxt   = CNT_W'(COLUMNS) - CNT_W'(col_r);
                col_nxt   = '0;
                state_nxt = ST_SWEEP;
              end
            end
            ttdc_pkg::OP_ERASE_LINE: begin
              prow_nxt  = cur_prow;
              pcol_nxt  = '0;
              cnt_nxt   = CNT_W'(COLUMNS);
              state_nxt = ST_SWEEP;
            end
            ttdc_pkg::OP_SCROLL: begin
              start_nxt = start_inc;
              row_nxt   = row_dec;
            end
            ttdc_pkg::OP_HOME: begin
              row_nxt = '0;
              col_nxt = '0;
            end
            ttdc_pkg::OP_COL0: begin
              col_nxt = '0;
            end
            ttdc_pkg::OP_CHAR: begin
              mem_we    = 1'b1;
              mem_waddr = cell_of(cur_prow, col_r);
              mem_wdata = q_head.code;
              if (last_col) begin
                col_nxt = '0;
                if (last_row) begin
                  start_nxt = start_inc;
                  prow_nxt  = start_r;
                  pcol_nxt  = '0;
                  cnt_nxt   = CNT_W'(COLUMNS);
                  state_nxt = ST_SWEEP;
                end else begin
                  row_nxt = row_inc;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RDMOD: begin
        if (rd_addr_r >= AW'(CELLS)) begin
          rd_addr_nxt = rd_addr_r - AW'(CELLS);
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_RDWAIT;
        end
      end

      ST_RDWAIT: begin
        res_read_nxt = mem_rdata_r;
        state_nxt    = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_read_nxt   = res_read_r;
          out_cursor_nxt = ttdc_pkg::CURSOR_W'(cursor_full);
          out_top_nxt    = ttdc_pkg::TOP_W'(start_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    res_read_r   <= res_read_nxt;
    out_read_r   <= out_read_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_top_r    <= out_top_nxt;
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      start_r     <= '0;
      prow_r      <= '0;
      pcol_r      <= '0;
      cnt_r       <= CNT_W'(CELLS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      start_r     <= start_nxt;
      prow_r      <= prow_nxt;
      pcol_r      <= pcol_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/text_terminal_display_controller_top.sv =====
// text terminal display controller: ROWS x COLUMNS character screen in a
// cell store with a rolling top row
// input channel (in_valid / in_stall): in_action 0 writes in_data_byte to the
// display port, 1 reads the store cell at in_cell_address (mod cell count)
// result channel (out_valid / out_stall): one item per input item, in order,
// carrying the read character (0 for writes), cursor index and top row
// a front stage latches the port byte and decodes the item into a two-entry
// queue; the back stage executes it against the store, one cell per cycle
// cursor-only commands and most characters need no sweep in the back stage;
// reads first reduce the address by subtracting the cell count until it is in
// range; line erases, a line feed on the last row, a character in the last
// cell, an end-of-line erase (COLUMNS - column cells) and a page clear blank
// their cells one at a time through the single store write port
// after reset the back stage fills all ROWS * COLUMNS cells (1024 by default)
// of the store with spaces while in_stall is held high
// a stalled result sits in the output register; further items queue up and
// in_stall rises once the queue is full
module text_terminal_display_controller_top #(
  parameter int COLUMNS     = ttdc_pkg::COLUMNS_DEF,
  parameter int ROWS        = ttdc_pkg::ROWS_DEF,
  parameter int QUEUE_DEPTH = ttdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [ttdc_pkg::DATA_W-1:0]   in_data_byte,
  input  logic [ttdc_pkg::ADDR_W-1:0]   in_cell_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ttdc_pkg::CODE_W-1:0]   out_read_data,
  output logic [ttdc_pkg::CURSOR_W-1:0] out_cursor_index,
  output logic [ttdc_pkg::TOP_W-1:0]    out_top_row
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  logic           back_busy;
  ttdc_pkg::cmd_t q_entry;
  ttdc_pkg::cmd_t q_head;

  ttdc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .in_cell_address (in_cell_address),
    .q_full          (q_full),
    .back_busy       (back_busy),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  ttdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  ttdc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .busy             (back_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_cursor_index (out_cursor_index),
    .out_top_row      (out_top_row)
  );

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ttdc_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int NROWS = ROWS_DEF;
  localparam int CELLS = COLS * NROWS;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 1100;

  typedef struct packed {
    logic [CODE_W-1:0]   rd;
    logic [CURSOR_W-1:0] cursor;
    logic [TOP_W-1:0]    top;
  } screen_report_t;

  typedef struct packed {
    logic                action;
    logic [DATA_W-1:0]   data;
    logic [ADDR_W-1:0]   addr;
    logic                typed;
    screen_report_t      want;
  } stim_row_t;

  localparam int TABLE_ROWS = 26;
  localparam stim_row_t DIRECTED[TABLE_ROWS] = '{
    '{1'b1, 8'h00, 10'd0, 1'b1, '{SPACE_CHAR, 10'd0, 4'd0}},
    '{1'b1, 8'hff, 10'd1023, 1'b1, '{SPACE_CHAR, 10'd0, 4'd0}},
    '{1'b0, 8'h00, 10'd0, 1'b1, '{7'd0, 10'd0, 4'd0}},
    '{1'b0, {1'b0, 7'h7f}, 10'd1023, 1'b1, '{7'd0, 10'd0, 4'd0}},
    '{1'b0, {1'b1, 7'h41}, 10'd0, 1'b1, '{7'd0, 10'd1, 4'd0}},
    '{1'b0, {1'b1, 7'h41}, 10'd0, 1'b1, '{7'd0, 10'd1, 4'd0}},
    '{1'b1, 8'h00, 10'd0, 1'b1, '{7'h41, 10'd1, 4'd0}},
    '{1'b0, {1'b1, CODE_LEFT}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b0, CODE_LEFT}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_LEFT}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, 7'h7f}, 10'd0, 1'b0, '0},
    '{1'b1, 8'h00, 10'd1023, 1'b0, '0},
    '{1'b0, {1'b1, CODE_DOWN}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_UP}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_RIGHT}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_CR}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_SCROLL}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_COL0}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_ERASE_LINE}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_HOME}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_NUL}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_IGNORE_A}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_IGNORE_B}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_IGNORE_C}, 10'd0, 1'b0, '0},
    '{1'b0, {1'b1, CODE_PAGE_CLEAR}, 10'd0, 1'b1, '{7'd0, 10'd0, 4'd0}},
    '{1'b1, 8'h00, 10'd0, 1'b1, '{SPACE_CHAR, 10'd0, 4'd0}}
  };

  localparam int CMD_COUNT = 13;
  localparam logic [CODE_W-1:0] CMD_CODES[CMD_COUNT] = '{
    CODE_NUL, CODE_IGNORE_A, CODE_LEFT, CODE_RIGHT, CODE_DOWN, CODE_UP, CODE_CR,
    CODE_IGNORE_B, CODE_IGNORE_C, CODE_ERASE_LINE, CODE_SCROLL, CODE_HOME, CODE_COL0
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_action = 1'b0;
  logic [DATA_W-1:0]   in_data_byte = '0;
  logic [ADDR_W-1:0]   in_cell_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CODE_W-1:0]   out_read_data;
  logic [CURSOR_W-1:0] out_cursor_index;
  logic [TOP_W-1:0]    out_top_row;

  logic [CODE_W-1:0]   shadow_cells[CELLS];
  int unsigned         shadow_cursor;
  int unsigned         shadow_top;
  logic [DATA_W-1:0]   shadow_latch;

  screen_report_t      due_reports[$];
  int unsigned         mismatch_count = 0;
  int unsigned         send_idle_pct = 11;
  int unsigned         recv_idle_pct = 69;
  logic [DATA_W-1:0]   last_port_byte = '0;

  text_terminal_display_controller_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_cell_address  (in_cell_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_cursor_index (out_cursor_index),
    .out_top_row      (out_top_row)
  );

  always #6 clk = ~clk;

  function automatic void blank_cell(int unsigned idx);
    shadow_cells[(COLS * shadow_top + idx) % CELLS] = SPACE_CHAR;
  endfunction

  function automatic void blank_row_from(int unsigned idx);
    for (int i = 0; i < COLS; i++) blank_cell(idx + i);
  endfunction

  function automatic void roll_top();
    shadow_top = (shadow_top + 1) % NROWS;
  endfunction

  function automatic void run_code(logic [CODE_W-1:0] code);
    int unsigned col;
    int unsigned c;
    col = shadow_cursor % COLS;
    case (code)
      CODE_NUL, CODE_IGNORE_A, CODE_IGNORE_B, CODE_IGNORE_C: begin
      end
      CODE_LEFT: shadow_cursor = (shadow_cursor + CELLS - 1) % CELLS;
      CODE_RIGHT: shadow_cursor = (shadow_cursor + 1) % CELLS;
      CODE_DOWN: begin
        if (shadow_cursor + COLS >= CELLS) begin
          roll_top();
          blank_row_from(shadow_cursor);
        end else begin
          shadow_cursor += COLS;
        end
      end
      CODE_UP: shadow_cursor = (shadow_cursor + CELLS - COLS) % CELLS;
      CODE_PAGE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = SPACE_CHAR;
        shadow_cursor = 0;
        shadow_top = 0;
      end
      CODE_CR: begin
        if (col != 0) begin
          for (c = shadow_cursor; (c % COLS) != 0; c++) blank_cell(c);
          shadow_cursor -= col;
        end
      end
      CODE_ERASE_LINE: blank_row_from(shadow_cursor - col);
      CODE_SCROLL: begin
        roll_top();
        shadow_cursor = (shadow_cursor + CELLS - COLS) % CELLS;
      end
      CODE_HOME: shadow_cursor = 0;
      CODE_COL0: shadow_cursor -= col;
      default: begin
        shadow_cells[(COLS * shadow_top + shadow_cursor) % CELLS] = code;
        shadow_cursor++;
        if (shadow_cursor >= CELLS) begin
          shadow_cursor -= COLS;
          roll_top();
          blank_row_from(shadow_cursor);
        end
      end
    endcase
  endfunction

  function automatic screen_report_t terminal_step(logic action, logic [DATA_W-1:0] data,
                                                   logic [ADDR_W-1:0] addr);
    screen_report_t rep;
    rep.rd = '0;
    if (action) begin
      rep.rd = shadow_cells[addr % CELLS];
    end else if (data != shadow_latch) begin
      shadow_latch = data;
      if (data[STROBE_BIT]) run_code(data[CODE_W-1:0]);
    end
    rep.cursor = shadow_cursor[CURSOR_W-1:0];
    rep.top = shadow_top[TOP_W-1:0];
    return rep;
  endfunction

  task automatic send_item(logic action, logic [DATA_W-1:0] data, logic [ADDR_W-1:0] addr,
                           logic typed, screen_report_t want);
    screen_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_data_byte <= data;
    in_cell_address <= addr;
    do @(posedge clk); while (in_stall);
    rep = terminal_step(action, data, addr);
    due_reports.push_back(typed ? want : rep);
    if (!action) last_port_byte = data;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [DATA_W-1:0] data;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_item(1'b1, DATA_W'($urandom), ADDR_W'($urandom), 1'b0, '0);
      return;
    end
    if (pick < 75) begin
      if ($urandom_range(9) < 7) code = CODE_W'($urandom_range(32, 127));
      else code = CODE_W'($urandom_range(31));
      data = {1'b1, code};
    end else if (pick < 95) begin
      if ($urandom_range(59) == 0) code = CODE_PAGE_CLEAR;
      else code = CMD_CODES[$urandom_range(CMD_COUNT - 1)];
      data = {1'b1, code};
    end else begin
      data = DATA_W'($urandom);
    end
    // a strobe-clear byte in between lets the same command act twice
    if (data == last_port_byte && $urandom_range(3) != 0)
      send_item(1'b0, {1'b0, data[CODE_W-1:0]}, ADDR_W'($urandom), 1'b0, '0);
    send_item(1'b0, data, ADDR_W'($urandom), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          $display("%t unexpected item: read_data %0d cursor_index %0d top_row %0d", $time,
                   out_read_data, out_cursor_index, out_top_row);
          mismatch_count++;
        end else begin
          if (out_read_data !== due_reports[0].rd) begin
            $display("%t read_data mismatch: expected %0d actual %0d", $time,
                     due_reports[0].rd, out_read_data);
            mismatch_count++;
          end
          if (out_cursor_index !== due_reports[0].cursor) begin
            $display("%t cursor_index mismatch: expected %0d actual %0d", $time,
                     due_reports[0].cursor, out_cursor_index);
            mismatch_count++;
          end
          if (out_top_row !== due_reports[0].top) begin
            $display("%t top_row mismatch: expected %0d actual %0d", $time,
                     due_reports[0].top, out_top_row);
            mismatch_count++;
          end
          void'(due_reports.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = SPACE_CHAR;
    shadow_cursor = 0;
    shadow_top = 0;
    shadow_latch = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < TABLE_ROWS; r++)
      send_item(DIRECTED[r].action, DIRECTED[r].data, DIRECTED[r].addr,
                DIRECTED[r].typed, DIRECTED[r].want);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase != 0) begin
        // hold off until the block has drained
        in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        send_idle_pct = (phase == 1) ? 69 : 0;
        recv_idle_pct = (phase == 1) ? 11 : 0;
      end
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_random_item();
    end

    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
